FILE: hdl/mcm_pkg.sv
// shared types and constants for the meter code match register bank
package mcm_pkg;

  localparam int MaxCodes    = 3;
  localparam int NumCodesDef = 3;
  localparam int CodeW       = 40;
  localparam int CfgDataW    = 40;
  localparam int CfgIdxW     = 3;
  localparam int OpW         = 3;
  localparam int LenW        = 8;
  localparam int BytesW      = 48;
  localparam int ValueW      = 32;
  localparam int RdIdxW      = 8;
  localparam int HalfW       = 16;
  localparam int PendW       = 2;
  localparam int PersistW    = 3;
  localparam int VersionW    = 32;

  localparam logic [PendW-1:0]    NoCode       = 2'd3;
  localparam logic [7:0]          Terminator   = 8'hFF;
  localparam logic [LenW-1:0]     CodeLenFull  = 8'd6;
  localparam logic [LenW-1:0]     CodeLenEmpty = 8'd0;
  localparam logic [PersistW-1:0] PersistReset = 3'd4;
  localparam logic [VersionW-1:0] VersionReset = 32'd2024050601;

  localparam logic [CodeW-1:0] CodeReset [MaxCodes] = '{
    40'h01_0001_0800,
    40'h01_0002_0800,
    40'h01_0010_0700
  };

  typedef enum logic [OpW-1:0] {
    OpFrameReset = 3'd0,
    OpCode       = 3'd1,
    OpValue      = 3'd2,
    OpCommit     = 3'd3,
    OpRead       = 3'd4
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCodeZero   = 3'd0,
    CfgCodeOne    = 3'd1,
    CfgCodeTwo    = 3'd2,
    CfgPersistent = 3'd3,
    CfgVersion    = 3'd4
  } cfg_idx_e;

  // one input word
  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [LenW-1:0]   code_length;
    logic [BytesW-1:0] code_bytes;
    logic [ValueW-1:0] value_word;
    logic [RdIdxW-1:0] read_index;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic [HalfW-1:0] read_data;
    logic [PendW-1:0] pending_code;
  } res_t;

endpackage

FILE: hdl/mcm_bank.sv
// code match, staged and live word storage, and register file of the bank
module mcm_bank #(
  parameter int NUM_CODES = mcm_pkg::NumCodesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mcm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mcm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           exec_i,
  input  mcm_pkg::cmd_t                  cmd_i,
  output mcm_pkg::res_t                  res_o
);

  localparam int NumWords = 2 * NUM_CODES;
  localparam int WIdxW    = (NumWords > 1) ? $clog2(NumWords) : 1;

  logic [mcm_pkg::CodeW-1:0]     code_q [NUM_CODES];
  logic [mcm_pkg::PersistW-1:0]  persist_q;
  logic [mcm_pkg::VersionW-1:0]  version_q;

  logic [mcm_pkg::PendW-1:0]     pend_q, pend_d;
  logic [NumWords-1:0]           flag_q, flag_d;
  logic [mcm_pkg::HalfW-1:0]     stage_q [NumWords];
  logic [mcm_pkg::HalfW-1:0]     stage_d [NumWords];
  logic [mcm_pkg::HalfW-1:0]     live_q  [NumWords];
  logic [mcm_pkg::HalfW-1:0]     live_d  [NumWords];

  logic                          hit;
  logic [mcm_pkg::PendW-1:0]     hit_idx;
  logic [mcm_pkg::CodeW-1:0]     head;
  logic [mcm_pkg::RdIdxW-1:0]    rd_off;
  logic [mcm_pkg::HalfW-1:0]     rd_data;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CODES; k++) begin
        code_q[k] <= mcm_pkg::CodeReset[k];
      end
      persist_q <= mcm_pkg::PersistReset;
      version_q <= mcm_pkg::VersionReset;
    end else if (cfg_we_i) begin
      for (int k = 0; k < NUM_CODES; k++) begin
        if (cfg_idx_i == mcm_pkg::CfgIdxW'(k)) begin
          code_q[k] <= cfg_data_i[mcm_pkg::CodeW-1:0];
        end
      end
      if (cfg_idx_i == mcm_pkg::CfgPersistent) begin
        persist_q <= cfg_data_i[mcm_pkg::PersistW-1:0];
      end
      if (cfg_idx_i == mcm_pkg::CfgVersion) begin
        version_q <= cfg_data_i[mcm_pkg::VersionW-1:0];
      end
    end
  end

  // lowest matching code wins
  assign head = cmd_i.code_bytes[mcm_pkg::BytesW-1:8];
  always_comb begin
    hit     = 1'b0;
    hit_idx = mcm_pkg::NoCode;
    for (int k = NUM_CODES - 1; k >= 0; k--) begin
      if (head == code_q[k]) begin
        hit     = 1'b1;
        hit_idx = mcm_pkg::PendW'(k);
      end
    end
  end

  // read mux
  assign rd_off = cmd_i.read_index - mcm_pkg::RdIdxW'(2);
  always_comb begin
    priority if (cmd_i.read_index == mcm_pkg::RdIdxW'(0)) begin
      rd_data = version_q[mcm_pkg::VersionW-1:mcm_pkg::HalfW];
    end else if (cmd_i.read_index == mcm_pkg::RdIdxW'(1)) begin
      rd_data = version_q[mcm_pkg::HalfW-1:0];
    end else if (cmd_i.read_index < mcm_pkg::RdIdxW'(NumWords + 2)) begin
      rd_data = live_q[rd_off[WIdxW-1:0]];
    end else begin
      rd_data = '0;
    end
  end

  always_comb begin
    pend_d  = pend_q;
    flag_d  = flag_q;
    stage_d = stage_q;
    live_d  = live_q;
    res_o.read_data = '0;
    unique case (cmd_i.opcode)
      mcm_pkg::OpFrameReset: begin
        pend_d = mcm_pkg::NoCode;
        flag_d = '0;
      end
      mcm_pkg::OpCode: begin
        if (cmd_i.code_length == mcm_pkg::CodeLenEmpty) begin
          pend_d = mcm_pkg::NoCode;
        end else if (cmd_i.code_length == mcm_pkg::CodeLenFull &&
                     cmd_i.code_bytes[7:0] == mcm_pkg::Terminator && hit) begin
          pend_d = hit_idx;
        end
      end
      mcm_pkg::OpValue: begin
        if (pend_q != mcm_pkg::NoCode) begin
          for (int w = 0; w < NumWords; w++) begin
            if (pend_q == mcm_pkg::PendW'(w / 2)) begin
              flag_d[w]  = 1'b1;
              stage_d[w] = (w % 2 == 0) ? cmd_i.value_word[mcm_pkg::ValueW-1:mcm_pkg::HalfW]
                                        : cmd_i.value_word[mcm_pkg::HalfW-1:0];
            end
          end
          pend_d = mcm_pkg::NoCode;
        end
      end
      mcm_pkg::OpCommit: begin
        for (int w = 0; w < NumWords; w++) begin
          if (flag_q[w]) begin
            flag_d[w] = 1'b0;
            live_d[w] = stage_q[w];
          end else if (mcm_pkg::PersistW'(w) >= persist_q) begin
            live_d[w] = '0;
          end
        end
        pend_d = mcm_pkg::NoCode;
      end
      mcm_pkg::OpRead: begin
        res_o.read_data = rd_data;
      end
      default: begin
      end
    endcase
    res_o.pending_code = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= mcm_pkg::NoCode;
      flag_q <= '0;
      for (int w = 0; w < NumWords; w++) begin
        stage_q[w] <= '0;
        live_q[w]  <= '0;
      end
    end else if (exec_i) begin
      pend_q  <= pend_d;
      flag_q  <= flag_d;
      stage_q <= stage_d;
      live_q  <= live_d;
    end
  end

  a_commit_clears_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && cmd_i.opcode == mcm_pkg::OpCommit |=> pend_q == mcm_pkg::NoCode)
    else $error("pending code survived a commit");

  a_frame_reset_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && cmd_i.opcode == mcm_pkg::OpFrameReset |=> flag_q == '0)
    else $error("staged flags survived a frame reset");

  a_read_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.opcode != mcm_pkg::OpRead |-> res_o.read_data == '0)
    else $error("nonzero data on a non-read word");

endmodule

FILE: hdl/meter_code_match_register_bank_core.sv
// top level of the meter code match register bank
//
// input channel: in_valid_i / in_stall_o with one command word per accept
// (opcode, code length, code bytes, value, read index)
// output channel: out_valid_o / out_stall_i, one result word per command:
// read data (zero for anything but a read) and the pending code after it
// config port: cfg_we_i writes cfg_data_i to register cfg_idx_i; the user must
// write only while the bank is idle (the block does not enforce it); indices
// 0..2 codes, 3 persistent count, 4 version word, other indices are dropped
// timing: the input register takes the word at the accept edge, the result
// register takes it when the word advances out of the input register;
// throughput one word per cycle while the output is not stalled, set by the
// combinational execute path between the two registers
// stall: a stalled result holds in the result register; the input register
// still takes a word, and in_stall_o rises only when both registers are full
// reset: codes, persistent count and version return to defaults, pending
// code is none, staged flags clear, staged and live words zero
module meter_code_match_register_bank_core #(
  parameter int NUM_CODES = mcm_pkg::NumCodesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mcm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mcm_pkg::OpW-1:0]       opcode_i,
  input  logic [mcm_pkg::LenW-1:0]      code_length_i,
  input  logic [mcm_pkg::BytesW-1:0]    code_bytes_i,
  input  logic [mcm_pkg::ValueW-1:0]    value_word_i,
  input  logic [mcm_pkg::RdIdxW-1:0]    read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mcm_pkg::HalfW-1:0]     read_data_o,
  output logic [mcm_pkg::PendW-1:0]     pending_code_o
);

  logic           in_vld_q, in_vld_d;
  mcm_pkg::cmd_t  cmd_q;
  logic           out_vld_q, out_vld_d;
  mcm_pkg::res_t  res_q, res;
  logic           in_acc;
  logic           advance;

  // word moves from input register to result register
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q.opcode      <= opcode_i;
      cmd_q.code_length <= code_length_i;
      cmd_q.code_bytes  <= code_bytes_i;
      cmd_q.value_word  <= value_word_i;
      cmd_q.read_index  <= read_index_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  mcm_bank #(
    .NUM_CODES(NUM_CODES)
  ) u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .exec_i    (advance),
    .cmd_i     (cmd_q),
    .res_o     (res)
  );

  assign out_valid_o    = out_vld_q;
  assign read_data_o    = res_q.read_data;
  assign pending_code_o = res_q.pending_code;

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("executed word did not reach the result register");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && out_stall_i |-> !advance)
    else $error("word executed while the result register was held");

endmodule
